FILE: rtl/core/qdd_pkg.sv
// Shared types, constants and the transition table of the quadrature detent decoder.
package qdd_pkg;

	// field and register widths
	localparam int DETENT_W          = 4;
	localparam int ACC_W             = 5;
	localparam int OUT_W             = 16;
	localparam int PENDING_WIDTH_DEF = 16;

	// reset values
	localparam logic [DETENT_W-1:0] DETENT_RESET = DETENT_W'(4);
	localparam logic [1:0]          LINES_IDLE   = 2'b11;

	// word operation codes
	typedef enum logic {
		OP_SAMPLE = 1'b0,
		OP_POLL   = 1'b1
	} op_t;

	// step per transition, indexed by {previous a, previous b, current a, current b}
	localparam logic signed [1:0] STEP_LUT [16] = '{
		2'sd0, -2'sd1, 2'sd1, 2'sd0,
		2'sd1, 2'sd0, 2'sd0, -2'sd1,
		-2'sd1, 2'sd0, 2'sd0, 2'sd1,
		2'sd0, 2'sd1, -2'sd1, 2'sd0
	};

	// detent event raised by the step logic
	typedef struct packed {
		logic up;
		logic down;
	} detent_evt_t;

endpackage

FILE: rtl/core/qdd_step.sv
// Transition lookup and step accumulation for one line sample.
module qdd_step (
	input  logic [1:0]                           prev_lines,
	input  logic [1:0]                           cur_lines,
	input  logic signed [qdd_pkg::ACC_W-1:0]     acc,
	input  logic [qdd_pkg::DETENT_W-1:0]         detent_steps,
	output logic signed [qdd_pkg::ACC_W-1:0]     acc_next,
	output qdd_pkg::detent_evt_t                 evt
);
	import qdd_pkg::*;

	logic signed [1:0]       delta;
	logic signed [ACC_W-1:0] sum;
	logic signed [ACC_W-1:0] pos_lim;
	logic signed [ACC_W-1:0] neg_lim;

	// look up the step and form the trial sum
	always_comb begin
		delta   = STEP_LUT[{prev_lines, cur_lines}];
		sum     = acc + ACC_W'(delta);
		pos_lim = $signed({1'b0, detent_steps});
		neg_lim = -pos_lim;
	end

	// compare against the detent limits, clear on a whole detent
	always_comb begin
		acc_next = acc;
		evt      = '0;
		if (delta != 2'sd0) begin
			if (sum >= pos_lim) begin
				acc_next = '0;
				evt.up   = 1'b1;
			end else if (sum <= neg_lim) begin
				acc_next  = '0;
				evt.down  = 1'b1;
			end else begin
				acc_next = sum;
			end
		end
	end

endmodule

FILE: rtl/core/quadrature_detent_decoder_top.sv
// Top level of the quadrature detent decoder: input register, state and result register.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+------------------------------------
//  in      | in        | in_valid / in_stall  | operation, line_a, line_b
//  out     | out       | out_valid / out_stall| pending_detents (16-bit signed)
//  cfg     | in        | cfg_valid / cfg_ready| cfg_data (detent_steps, 4 bits)
//
// One word per cycle while in_stall is low: a word is registered in the input register, then processed from there.
// A poll loads the result register from the input register, once that register is
// free or being emptied; a sample gives no result.
// Reset puts the lines at both high, the accumulator and pending count at zero and
// detent_steps at 4; cfg_ready is always high.
// A stalled result only holds back a poll in the input register; samples pass it.
module quadrature_detent_decoder_top #(
	parameter int PENDING_WIDTH = qdd_pkg::PENDING_WIDTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                operation,
	input  logic                                line_a,
	input  logic                                line_b,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [qdd_pkg::OUT_W-1:0]    pending_detents,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [qdd_pkg::DETENT_W-1:0]        cfg_data
);
	import qdd_pkg::*;

	localparam int WIDE = (PENDING_WIDTH > OUT_W) ? PENDING_WIDTH : OUT_W;
	localparam logic signed [PENDING_WIDTH-1:0] PEND_MAX = {1'b0, {(PENDING_WIDTH-1){1'b1}}};
	localparam logic signed [PENDING_WIDTH-1:0] PEND_MIN = {1'b1, {(PENDING_WIDTH-1){1'b0}}};
	localparam logic signed [WIDE-1:0]          OUT_MAX  = WIDE'(32767);
	localparam logic signed [WIDE-1:0]          OUT_MIN  = WIDE'(-32768);

	logic                              valid_s1;
	op_t                               op_s1;
	logic [1:0]                        lines_s1;
	logic [DETENT_W-1:0]               detent_q;
	logic [1:0]                        prev_lines_q;
	logic signed [ACC_W-1:0]           acc_q;
	logic signed [PENDING_WIDTH-1:0]   pending_q;
	logic                              out_valid_q;
	logic signed [OUT_W-1:0]           out_data_q;

	logic                              advance;
	logic                              take;
	logic                              is_poll;
	logic signed [ACC_W-1:0]           acc_next;
	detent_evt_t                       evt;
	logic signed [WIDE-1:0]            pend_ext;
	logic signed [OUT_W-1:0]           pend_clamped;

	// drop a poll only when the result register is free or being emptied
	always_comb begin
		is_poll  = (op_s1 == OP_POLL);
		advance  = valid_s1 && (!is_poll || !out_valid_q || !out_stall);
		in_stall = valid_s1 && !advance;
		take     = in_valid && !in_stall;
	end

	assign cfg_ready       = 1'b1;
	assign out_valid       = out_valid_q;
	assign pending_detents = out_data_q;

	qdd_step u_step (
		.prev_lines   (prev_lines_q),
		.cur_lines    (lines_s1),
		.acc          (acc_q),
		.detent_steps (detent_q),
		.acc_next     (acc_next),
		.evt          (evt)
	);

	// clamp the pending count to the output range
	always_comb begin
		pend_ext = WIDE'(pending_q);
		if (pend_ext > OUT_MAX) begin
			pend_clamped = OUT_W'(OUT_MAX);
		end else if (pend_ext < OUT_MIN) begin
			pend_clamped = OUT_W'(OUT_MIN);
		end else begin
			pend_clamped = OUT_W'(pend_ext);
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			op_s1    <= op_t'(operation);
			lines_s1 <= {line_a, line_b};
		end
	end

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			detent_q <= DETENT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			detent_q <= cfg_data;
		end
	end

	// advance decoder state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_lines_q <= LINES_IDLE;
			acc_q        <= '0;
			pending_q    <= '0;
		end else if (advance) begin
			if (is_poll) begin
				pending_q <= '0;
			end else begin
				prev_lines_q <= lines_s1;
				acc_q        <= acc_next;
				if (evt.up && pending_q != PEND_MAX) begin
					pending_q <= pending_q + PENDING_WIDTH'(1);
				end else if (evt.down && pending_q != PEND_MIN) begin
					pending_q <= pending_q - PENDING_WIDTH'(1);
				end
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && is_poll) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && is_poll) begin
			out_data_q <= pend_clamped;
		end
	end

endmodule

FILE: rtl/core/qdd_checker.sv
// Port-level checks for the quadrature detent decoder, bound to the top level.
module qdd_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             in_valid,
	input logic                             in_stall,
	input logic                             operation,
	input logic                             out_valid,
	input logic                             out_stall,
	input logic signed [qdd_pkg::OUT_W-1:0] pending_detents
);

	// hold a stalled result word
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(pending_detents))
		else $error("stalled result word changed");

	// stall only while a word taken earlier is still held
	assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> $past(in_valid && !in_stall) || $past(in_stall))
		else $error("input stalled with nothing held");

	// a fresh result follows a poll taken earlier
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && !in_stall && operation, 2))
		else $error("result word without a poll");

endmodule

bind quadrature_detent_decoder_top qdd_checker u_qdd_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.in_valid        (in_valid),
	.in_stall        (in_stall),
	.operation       (operation),
	.out_valid       (out_valid),
	.out_stall       (out_stall),
	.pending_detents (pending_detents)
);
